// File: rtl/core/dark_channel_min_filter_defines.svh
// Assertion macros for the dark channel minimum filter.
`ifndef DARK_CHANNEL_MIN_FILTER_DEFINES_SVH
`define DARK_CHANNEL_MIN_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DCMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dcmf check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define DCMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dcmf check failed");

`endif

// File: rtl/core/dcmf_pkg.sv
// Shared types, constants and helper functions of the dark channel minimum filter.
`timescale 1ns / 1ps
package dcmf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 7;
    localparam int MAX_HEIGHT     = 4096;

    localparam logic [7:0] PIX_MAX = 8'd255;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // Field widths sized for the largest parameter values.
    localparam int POS_XW = 12;
    localparam int POS_YW = 13;
    localparam int LINE_W = 5;
    localparam int CFG_WW = 13;
    localparam int CFG_HW = 13;
    localparam int CFG_RW = 4;

    localparam int TREE_N  = 32;
    localparam int TREE_LV = 5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] blue;
        logic [7:0] green;
    } t_in;

    typedef struct packed {
        logic [7:0] dark_value;
        logic       last_of_frame;
    } t_out;

    typedef struct packed {
        logic [CFG_WW-1:0] width;
        logic [CFG_HW-1:0] height;
        logic [CFG_RW-1:0] radius;
    } t_cfg;

    typedef struct packed {
        logic              is_pix;
        logic [7:0]        value;
        logic [POS_XW-1:0] x;
        logic [POS_YW-1:0] y;
        logic [LINE_W-1:0] line;
        logic              v_en;
        logic              emit;
        logic              last;
        logic [POS_XW-1:0] ox;
    } t_job;

    function automatic logic [7:0] min8(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    // Balanced minimum over TREE_N bytes, one level of pairs per pass.
    function automatic logic [7:0] min_tree(input logic [TREE_N-1:0][7:0] v);
        logic [TREE_N-1:0][7:0] a;
        a = v;
        for (int lv = 0; lv < TREE_LV; lv++) begin
            for (int i = 0; i < TREE_N / 2; i++) begin
                a[i] = min8(a[2*i], a[2*i+1]);
            end
        end
        return a[0];
    endfunction

endpackage

// File: rtl/core/dcmf_front.sv
// Front end: configuration registers, item classification and position counters.
`timescale 1ns / 1ps
module dcmf_front #(
    parameter int MAX_WIDTH  = dcmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = dcmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [dcmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dcmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    input  dcmf_pkg::t_in                   i_in_data,
    input  logic                            i_q_full,
    output logic                            o_in_ready,
    output logic                            o_push,
    output dcmf_pkg::t_job                  o_job,
    output dcmf_pkg::t_cfg                  o_cfg
);

    localparam int LANES = 2 * MAX_RADIUS + 1;
    localparam int LAG_W = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [2:0]  r_radius;

    logic [dcmf_pkg::POS_XW-1:0] r_x, r_ox;
    logic [dcmf_pkg::POS_YW-1:0] r_y, r_oy;
    logic [dcmf_pkg::LINE_W-1:0] r_line;
    logic [LAG_W-1:0]            r_lead;

    dcmf_pkg::t_cfg   w_cfg;
    logic [LAG_W-1:0] w_lag;
    logic             w_accept, w_pix, w_flush, w_fill, w_emit, w_last;
    logic [7:0]       w_min;

    always_comb begin
        if (r_width == 11'd0) begin
            w_cfg.width = dcmf_pkg::CFG_WW'(1);
        end else if ({2'b0, r_width} > dcmf_pkg::CFG_WW'(MAX_WIDTH)) begin
            w_cfg.width = dcmf_pkg::CFG_WW'(MAX_WIDTH);
        end else begin
            w_cfg.width = {2'b0, r_width};
        end
        if (r_height == 13'd0) begin
            w_cfg.height = dcmf_pkg::CFG_HW'(1);
        end else if (r_height > dcmf_pkg::CFG_HW'(dcmf_pkg::MAX_HEIGHT)) begin
            w_cfg.height = dcmf_pkg::CFG_HW'(dcmf_pkg::MAX_HEIGHT);
        end else begin
            w_cfg.height = r_height;
        end
        if ({1'b0, r_radius} > dcmf_pkg::CFG_RW'(MAX_RADIUS)) begin
            w_cfg.radius = dcmf_pkg::CFG_RW'(MAX_RADIUS);
        end else begin
            w_cfg.radius = {1'b0, r_radius};
        end
    end

    assign o_cfg = w_cfg;
    assign w_lag = LAG_W'(w_cfg.radius) * LAG_W'(w_cfg.width) + LAG_W'(w_cfg.radius);

    // Past the last pixel of a short frame, step the window alone until the lag is reached.
    assign w_fill     = w_flush && (r_lead != w_lag);
    assign o_in_ready = !i_q_full && !w_fill;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_pix      = (i_in_data.cmd == dcmf_pkg::CMD_PIXEL) && (r_y < w_cfg.height);
    assign w_flush    = (r_y >= w_cfg.height);
    assign o_push     = (w_accept && (w_pix || w_flush)) || (w_fill && !i_q_full);

    assign w_emit = (r_lead == w_lag);
    assign w_last = w_emit && (r_oy == w_cfg.height - 1'b1)
                  && ({1'b0, r_ox} == w_cfg.width - 1'b1);

    // Zero never wins: map it to full scale.
    always_comb begin
        w_min = dcmf_pkg::min8(i_in_data.blue, i_in_data.green);
        if (w_min == 8'd0) begin
            w_min = dcmf_pkg::PIX_MAX;
        end
        o_job.is_pix = w_pix;
        o_job.value  = w_min;
        o_job.x      = r_x;
        o_job.y      = r_y;
        o_job.line   = r_line;
        o_job.v_en   = (r_y >= dcmf_pkg::POS_YW'(w_cfg.radius));
        o_job.emit   = w_emit;
        o_job.last   = w_last;
        o_job.ox     = r_ox;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd1024;
            r_height <= 13'd1024;
            r_radius <= 3'd5;
            r_x      <= '0;
            r_y      <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_line   <= '0;
            r_lead   <= '0;
        end else if (i_cfg_we && (i_cfg_index == dcmf_pkg::REG_FRAME_WIDTH
                               || i_cfg_index == dcmf_pkg::REG_FRAME_HEIGHT
                               || i_cfg_index == dcmf_pkg::REG_WINDOW_RADIUS)) begin
            case (i_cfg_index)
                dcmf_pkg::REG_FRAME_WIDTH:   r_width  <= i_cfg_data[10:0];
                dcmf_pkg::REG_FRAME_HEIGHT:  r_height <= i_cfg_data[12:0];
                dcmf_pkg::REG_WINDOW_RADIUS: r_radius <= i_cfg_data[2:0];
                default: ;
            endcase
            // Drop the frame in progress.
            r_x    <= '0;
            r_y    <= '0;
            r_ox   <= '0;
            r_oy   <= '0;
            r_line <= '0;
            r_lead <= '0;
        end else if (o_push) begin
            if (w_last) begin
                r_x    <= '0;
                r_y    <= '0;
                r_ox   <= '0;
                r_oy   <= '0;
                r_line <= '0;
                r_lead <= '0;
            end else begin
                if ({1'b0, r_x} == w_cfg.width - 1'b1) begin
                    r_x    <= '0;
                    r_y    <= r_y + 1'b1;
                    r_line <= (r_line == dcmf_pkg::LINE_W'(LANES - 1)) ? '0 : r_line + 1'b1;
                end else begin
                    r_x <= r_x + 1'b1;
                end
                if (!w_emit) begin
                    r_lead <= r_lead + 1'b1;
                end else if ({1'b0, r_ox} == w_cfg.width - 1'b1) begin
                    r_ox <= '0;
                    r_oy <= r_oy + 1'b1;
                end else begin
                    r_ox <= r_ox + 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/core/dcmf_queue.sv
// Short job queue between the front end and the window pipeline.
`timescale 1ns / 1ps
module dcmf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dcmf_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output dcmf_pkg::t_job o_job
);

    dcmf_pkg::t_job                r_mem [dcmf_pkg::QUEUE_DEPTH];
    logic [dcmf_pkg::QUEUE_AW-1:0] r_wp, r_rp;
    logic [dcmf_pkg::QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (dcmf_pkg::QUEUE_AW + 1)'(dcmf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/dcmf_back.sv
// Window pipeline: row line stores, vertical minimum, horizontal minimum, output register.
`timescale 1ns / 1ps
module dcmf_back #(
    parameter int MAX_WIDTH  = dcmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = dcmf_pkg::DEF_MAX_RADIUS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dcmf_pkg::t_cfg i_cfg,
    input  logic           i_q_valid,
    input  dcmf_pkg::t_job i_q_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output dcmf_pkg::t_out o_out_data
);

    localparam int LANES  = 2 * MAX_RADIUS + 1;
    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CW     = dcmf_pkg::POS_YW + 1;

    logic w_adv;

    logic [LANES-1:0] w_vmask;
    logic [7:0]       w_rd [LANES];

    logic             r_s1_valid;
    dcmf_pkg::t_job   r_s1_job;
    logic [LANES-1:0] r_s1_vmask;

    logic [dcmf_pkg::TREE_N-1:0][7:0] w_vvals, w_hvals;
    logic [7:0]       w_vmin, w_dark;
    logic [LANES-1:0] w_hmask;
    logic [CW-1:0]    w_t;

    logic             r_s2_valid, r_s2_emit, r_s2_last;
    logic [LANES-1:0] r_s2_hmask;
    logic [7:0]       r_hline [LANES];

    logic           r_out_valid;
    dcmf_pkg::t_out r_out_data;

    // Advance all stages together whenever the output slot frees.
    assign w_adv = !r_out_valid || i_out_ready;
    assign o_pop = w_adv && i_q_valid;

    // Lane p holds an older row; keep it when that row is inside both window and frame.
    always_comb begin
        for (int p = 0; p < LANES; p++) begin
            logic [dcmf_pkg::LINE_W-1:0] age;
            age = (i_q_job.line >= dcmf_pkg::LINE_W'(p))
                ? i_q_job.line - dcmf_pkg::LINE_W'(p)
                : i_q_job.line + dcmf_pkg::LINE_W'(LANES) - dcmf_pkg::LINE_W'(p);
            w_vmask[p] = (age != '0)
                && (CW'(age) <= CW'({i_cfg.radius, 1'b0}))
                && (CW'(age) <= CW'(i_q_job.y))
                && (CW'(age) + CW'(i_cfg.height) > CW'(i_q_job.y));
        end
    end

    for (genvar p = 0; p < LANES; p++) begin : g_lane
        logic [7:0] r_line_mem [MAX_WIDTH];
        logic [7:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (o_pop) begin
                if (i_q_job.is_pix && i_q_job.line == dcmf_pkg::LINE_W'(p)) begin
                    r_line_mem[i_q_job.x[ADDR_W-1:0]] <= i_q_job.value;
                end
                r_rd <= r_line_mem[i_q_job.x[ADDR_W-1:0]];
            end
        end

        assign w_rd[p] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_job   <= i_q_job;
            r_s1_vmask <= w_vmask;
        end
    end

    // Vertical minimum, newest row straight from the job.
    always_comb begin
        w_vvals = {dcmf_pkg::TREE_N{dcmf_pkg::PIX_MAX}};
        for (int i = 0; i < LANES; i++) begin
            w_vvals[i] = r_s1_vmask[i] ? w_rd[i] : dcmf_pkg::PIX_MAX;
        end
        w_vvals[LANES] = r_s1_job.is_pix ? r_s1_job.value : dcmf_pkg::PIX_MAX;
        w_vmin = dcmf_pkg::min_tree(w_vvals);
    end

    // Entry i of the column line sits ox + R - i columns into the output row.
    always_comb begin
        w_t = CW'(r_s1_job.ox) + CW'(i_cfg.radius);
        for (int i = 0; i < LANES; i++) begin
            w_hmask[i] = (CW'(i) <= CW'({i_cfg.radius, 1'b0}))
                && (CW'(i) <= w_t)
                && (w_t < CW'(i_cfg.width) + CW'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_emit  <= r_s1_job.emit;
            r_s2_last  <= r_s1_job.last;
            r_s2_hmask <= w_hmask;
            if (r_s1_valid && r_s1_job.v_en) begin
                r_hline[0] <= w_vmin;
                for (int i = 1; i < LANES; i++) begin
                    r_hline[i] <= r_hline[i-1];
                end
            end
        end
    end

    always_comb begin
        w_hvals = {dcmf_pkg::TREE_N{dcmf_pkg::PIX_MAX}};
        for (int i = 0; i < LANES; i++) begin
            w_hvals[i] = r_s2_hmask[i] ? r_hline[i] : dcmf_pkg::PIX_MAX;
        end
        w_dark = dcmf_pkg::min_tree(w_hvals);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s2_valid && r_s2_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data.dark_value    <= w_dark;
            r_out_data.last_of_frame <= r_s2_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: rtl/core/dark_channel_min_filter.sv
// Top level of the dark channel minimum filter.
`timescale 1ns / 1ps
// Dark channel minimum filter for a raster pixel stream.
// Input channel (i_in_*): one beat per pixel carrying cmd, blue and green; cmd
// flush beats after the last pixel of a frame drain the pending results, one
// result per beat. A flush beat while pixels are still expected is taken and
// dropped; a pixel beat while results are pending acts as a flush.
// Output channel (o_out_*): one beat per result, dark_value plus last_of_frame
// on the final pixel of the frame. Results trail the pixels by R rows plus R
// pixels, R being the window radius.
// Config channel (i_cfg_*): always ready; a register write restarts the frame.
// Throughput: one beat per clock on both channels unless stalled. Each beat
// flows through a four-entry job queue, one line-store read (one row memory
// per lane, read once per cycle, written only by its own row), a vertical and
// a horizontal minimum tree and the stage-one, stage-two, output registers.
// When a frame is shorter than the lag, o_in_ready drops after its last pixel
// for R*W + R - W*H internal steps that bring the window to the first result.
// Stall: a held output beat freezes the window pipeline; the queue keeps
// taking input until it fills, then o_in_ready drops.
// Reset: synchronous, active low; registers return to 1024 x 1024, radius 5,
// and the frame position to the origin. The line stores have no clearing pass:
// rows outside the current frame are masked and never read as data.
module dark_channel_min_filter #(
    parameter int MAX_WIDTH  = dcmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = dcmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dcmf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dcmf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  dcmf_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output dcmf_pkg::t_out                  o_out_data
);

`include "dark_channel_min_filter_defines.svh"

    logic           w_push, w_q_full, w_q_valid, w_pop;
    dcmf_pkg::t_job w_job, w_q_job;
    dcmf_pkg::t_cfg w_cfg;

    // Register writes take effect at once; no wait is needed.
    assign o_cfg_ready = 1'b1;

    dcmf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_q_full    (w_q_full),
        .o_in_ready  (o_in_ready),
        .o_push      (w_push),
        .o_job       (w_job),
        .o_cfg       (w_cfg)
    );

    // Decouple classification from the window pipeline.
    dcmf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_job   (w_q_job)
    );

    dcmf_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_job     (w_q_job),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Never push into a full queue, never pop an empty one.
    `DCMF_ASSERT_IMP(a_no_overflow, w_push, !w_q_full)
    `DCMF_ASSERT_IMP(a_no_underflow, w_pop, w_q_valid)
    // A result job always carries a fresh column minimum.
    `DCMF_ASSERT_IMP(a_emit_has_column, w_pop && w_q_job.emit, w_q_job.v_en)
    // A full queue that is not drained keeps the input closed.
    `DCMF_ASSERT_NXT(a_full_holds, w_q_full && !w_pop, !o_in_ready)

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the dark channel minimum filter: random frames, stalls and checks.
`timescale 1ns / 1ps
module tb_top;

    localparam int RING_SIZE   = 16 * 1024;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 16;

    // Index past the last register; a write there changes nothing.
    localparam logic [dcmf_pkg::CFG_IDX_W-1:0] NO_SUCH_REG = 2'd3;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [dcmf_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [dcmf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    dcmf_pkg::t_in                   i_in_data = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    dcmf_pkg::t_out                  o_out_data;

    dark_channel_min_filter uut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow copy of the filter state
    logic [7:0]  line_ring [RING_SIZE];
    int unsigned ring_wr;
    int unsigned pix_col, pix_row, res_col, res_row;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  radius_reg;

    dcmf_pkg::t_in  pixel_queue [$];
    dcmf_pkg::t_out dark_queue [$];
    int   mismatches = 0;
    int   cycles = 0;
    bit   no_gaps = 0;
    int   in_gap = 0;
    int   out_stall = 0;

    function automatic int unsigned act_width();
        if (width_reg == 0) return 1;
        if (width_reg > dcmf_pkg::DEF_MAX_WIDTH) return dcmf_pkg::DEF_MAX_WIDTH;
        return width_reg;
    endfunction

    function automatic int unsigned act_height();
        if (height_reg == 0) return 1;
        if (height_reg > dcmf_pkg::MAX_HEIGHT) return dcmf_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    function automatic void rewind_frame();
        pix_col = 0; pix_row = 0; res_col = 0; res_row = 0;
    endfunction

    function automatic void reset_shadow();
        width_reg = 11'd1024; height_reg = 13'd1024; radius_reg = 3'd5;
        foreach (line_ring[k]) line_ring[k] = dcmf_pkg::PIX_MAX;
        ring_wr = 0;
        rewind_frame();
    endfunction

    function automatic void apply_reg_write(logic [dcmf_pkg::CFG_IDX_W-1:0] idx,
                                            logic [dcmf_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            dcmf_pkg::REG_FRAME_WIDTH:   width_reg  = val[10:0];
            dcmf_pkg::REG_FRAME_HEIGHT:  height_reg = val[12:0];
            dcmf_pkg::REG_WINDOW_RADIUS: radius_reg = val[2:0];
            default: return;
        endcase
        rewind_frame();
    endfunction

    function automatic void queue_beat(dcmf_pkg::t_in beat);
        pixel_queue.insert(pixel_queue.size(), beat);
    endfunction

    // Window minimum around the next result position; newest is the raster
    // index of the most recent stored pixel.
    function automatic void push_dark(int unsigned w, int unsigned h, int unsigned r,
                                      int unsigned newest);
        int unsigned    top, bot, lft, rgt, p, d, slot, newest_slot;
        logic [7:0]     m;
        dcmf_pkg::t_out res;
        newest_slot = (ring_wr + RING_SIZE - 1) % RING_SIZE;
        top = res_row >= r ? res_row - r : 0;
        bot = res_row + r < h ? res_row + r : h - 1;
        lft = res_col >= r ? res_col - r : 0;
        rgt = res_col + r < w ? res_col + r : w - 1;
        m = dcmf_pkg::PIX_MAX;
        for (int unsigned y = top; y <= bot; y++) begin
            for (int unsigned x = lft; x <= rgt; x++) begin
                p = y * w + x;
                d = newest >= p ? newest - p : 0;
                if (d >= RING_SIZE) d = RING_SIZE - 1;
                slot = (newest_slot + RING_SIZE - d) % RING_SIZE;
                if (line_ring[slot] < m) m = line_ring[slot];
            end
        end
        res.dark_value = m;
        res.last_of_frame = (res_row == h - 1) && (res_col == w - 1);
        dark_queue.insert(dark_queue.size(), res);
        if (res.last_of_frame) begin
            rewind_frame();
        end else begin
            res_col++;
            if (res_col >= w) begin
                res_col = 0;
                res_row++;
            end
        end
    endfunction

    function automatic void predict_beat(dcmf_pkg::t_in beat);
        int unsigned w, h, r, lag, newest;
        logic [7:0]  v;
        w = act_width(); h = act_height(); r = radius_reg;
        lag = r * w + r;
        if (beat.cmd == dcmf_pkg::CMD_PIXEL && pix_row < h) begin
            v = beat.blue < beat.green ? beat.blue : beat.green;
            if (v == 0) v = dcmf_pkg::PIX_MAX;
            line_ring[ring_wr] = v;
            ring_wr = (ring_wr + 1) % RING_SIZE;
            newest = pix_row * w + pix_col;
            pix_col++;
            if (pix_col >= w) begin
                pix_col = 0;
                pix_row++;
            end
            if (newest >= lag) push_dark(w, h, r, newest);
        end else if (pix_row >= h) begin
            push_dark(w, h, r, h * w - 1);
        end
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = int'($urandom_range(0, 99));
        if (no_gaps || sel < 55) return 0;
        if (sel < 92) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    // Driver: advance the input channel, predict on each accepted beat.
    always @(posedge i_clk) begin
        logic          nxt_valid;
        dcmf_pkg::t_in nxt_data;
        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_beat(i_in_data);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (pixel_queue.size() > 0) begin
                    nxt_data  = pixel_queue.pop_front();
                    nxt_valid = 1'b1;
                    in_gap    = pick_gap();
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data  <= nxt_data;
    end

    // Monitor: stall the output at random, check each accepted beat.
    always @(posedge i_clk) begin
        dcmf_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (dark_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: dark %0d last %0b",
                             o_out_data.dark_value, o_out_data.last_of_frame);
            end else begin
                want = dark_queue.pop_front();
                if (want.dark_value !== o_out_data.dark_value ||
                    want.last_of_frame !== o_out_data.last_of_frame) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected dark %0d last %0b, got dark %0d last %0b",
                                 want.dark_value, want.last_of_frame,
                                 o_out_data.dark_value, o_out_data.last_of_frame);
                end
            end
        end
        if (out_stall > 0) begin
            out_stall--;
            i_out_ready <= 1'b0;
        end else begin
            out_stall = pick_gap();
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pixel_queue.size() > 0 || i_in_valid || dark_queue.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [dcmf_pkg::CFG_IDX_W-1:0] idx,
                             logic [dcmf_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg_write(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_frame(int w, int h, int r);
        wait_idle();
        write_reg(dcmf_pkg::REG_FRAME_WIDTH, dcmf_pkg::CFG_DATA_W'(w));
        write_reg(dcmf_pkg::REG_FRAME_HEIGHT, dcmf_pkg::CFG_DATA_W'(h));
        write_reg(dcmf_pkg::REG_WINDOW_RADIUS, dcmf_pkg::CFG_DATA_W'(r));
    endtask

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = int'($urandom_range(0, 9));
        if (sel == 0) return 8'd0;
        if (sel == 1) return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic dcmf_pkg::t_in make_beat(logic cmd);
        dcmf_pkg::t_in b;
        b.cmd = cmd; b.blue = pick_byte(); b.green = pick_byte();
        return b;
    endfunction

    // Queue one frame plus its drain; noisy frames add stray flushes
    // mid-frame and stray pixels during the drain.
    function automatic int queue_frame(bit noisy);
        int unsigned w, h, r, pend, cnt;
        w = act_width(); h = act_height(); r = radius_reg;
        pend = r * w + r < w * h ? r * w + r : w * h;
        cnt = 0;
        for (int unsigned i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(0, 29) == 0) queue_beat(make_beat(dcmf_pkg::CMD_FLUSH));
            queue_beat(make_beat(dcmf_pkg::CMD_PIXEL));
            cnt++;
        end
        for (int unsigned i = 0; i < pend; i++) begin
            queue_beat(make_beat(noisy && $urandom_range(0, 3) == 0 ?
                                 dcmf_pkg::CMD_PIXEL : dcmf_pkg::CMD_FLUSH));
            cnt++;
        end
        return cnt;
    endfunction

    initial begin
        dcmf_pkg::t_in b;
        int            sent;
        reset_shadow();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: 3x2 frame, radius 1, channel extremes and both special cases
        set_frame(3, 2, 1);
        write_reg(NO_SUCH_REG, 13'h1FFF);
        b = '{cmd: dcmf_pkg::CMD_PIXEL, blue: 8'd0,   green: 8'd0};   queue_beat(b);
        b = '{cmd: dcmf_pkg::CMD_PIXEL, blue: 8'd255, green: 8'd255}; queue_beat(b);
        b = '{cmd: dcmf_pkg::CMD_FLUSH, blue: 8'd17,  green: 8'd3};   queue_beat(b);
        b = '{cmd: dcmf_pkg::CMD_PIXEL, blue: 8'd1,   green: 8'd200}; queue_beat(b);
        b = '{cmd: dcmf_pkg::CMD_PIXEL, blue: 8'd90,  green: 8'd0};   queue_beat(b);
        b = '{cmd: dcmf_pkg::CMD_PIXEL, blue: 8'd170, green: 8'd85};  queue_beat(b);
        b = '{cmd: dcmf_pkg::CMD_PIXEL, blue: 8'd128, green: 8'd127}; queue_beat(b);
        b = '{cmd: dcmf_pkg::CMD_PIXEL, blue: 8'd255, green: 8'd255}; queue_beat(b);
        b = '{cmd: dcmf_pkg::CMD_FLUSH, blue: 8'd0,   green: 8'd0};   queue_beat(b);
        b = '{cmd: dcmf_pkg::CMD_FLUSH, blue: 8'd0,   green: 8'd0};   queue_beat(b);
        b = '{cmd: dcmf_pkg::CMD_FLUSH, blue: 8'd0,   green: 8'd0};   queue_beat(b);

        // Register extremes: zero acts as one, oversize clamps
        set_frame(0, 0, 0);
        void'(queue_frame(1));
        // Oversize frames: run the head of each, then drop it
        set_frame(2047, 1, 0);
        repeat (40) queue_beat(make_beat(dcmf_pkg::CMD_PIXEL));
        set_frame(1, 8191, 7);
        repeat (60) queue_beat(make_beat(dcmf_pkg::CMD_PIXEL));
        set_frame(16, 3, 7);
        void'(queue_frame(1));

        // Drop a frame part way through with a register write
        set_frame(6, 5, 2);
        repeat (13) queue_beat(make_beat(dcmf_pkg::CMD_PIXEL));
        set_frame(5, 4, 1);
        // Hold the sender mid-frame until every result is in
        repeat (11) queue_beat(make_beat(dcmf_pkg::CMD_PIXEL));
        wait_idle();
        repeat (9) queue_beat(make_beat(dcmf_pkg::CMD_PIXEL));
        repeat (6) queue_beat(make_beat(dcmf_pkg::CMD_FLUSH));

        sent = 0;
        while (sent < 800) begin
            if ($urandom_range(0, 3) == 0)
                set_frame(int'($urandom_range(1, 40)), int'($urandom_range(1, 6)),
                          int'($urandom_range(0, 7)));
            else
                set_frame(int'($urandom_range(1, 12)), int'($urandom_range(1, 10)),
                          int'($urandom_range(0, 7)));
            no_gaps = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3)) sent += queue_frame($urandom_range(0, 3) == 0);
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
